>>> rtl/core/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg: shared types and constants for the coordinate sort partitioner
// Field widths, register indexes, axis codes, state codes and the chain op.
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int MAX_ELEMS_DEF  = 64;
    localparam int COORD_BITS_DEF = 24;

    localparam int ID_W       = 16;
    localparam int PARTS_W    = 7;
    localparam int PART_ID_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SORT_AXIS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_PARTS = 2'd1;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z,
        AXIS_RADIAL
    } axis_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic ins;
        logic shf;
    } chain_op_t;

endpackage

>>> rtl/core/coordinate_sort_partitioner_core.sv
// ----------------------------------------------------------------------------
// coordinate_sort_partitioner_core: sorts element centroids, assigns partitions
// Element requests enter on item_valid/item_ready with x, y, z and an id.
// The sort key (x, y, z or squared radius) and the partition count come from
// the cfg_valid/cfg_ready write port; cfg_ready is always high. Writes are to be
// made only while the block is idle; the block itself does not enforce this.
// Loading: one request per cycle while item_ready is high. A request forms its
// key in the square stage, then the sum stage, and is then placed in the
// insertion chain; every chain slot compares against the new key in parallel.
// A request with last_in closes the batch: item_ready drops, and after the key
// stages, the insertion and a divider run for the partition size, the sorted
// ids stream out on result_valid/result_ready, one per cycle while result_ready
// is high, by shifting the chain.
// A stalled receiver holds the current result and the whole chain in place.
// Requests beyond MAX_ELEMS are dropped and flag overflow on every result.
// After the last result the block accepts requests again. Reset empties the
// chain, selects the x key and one partition.
// ----------------------------------------------------------------------------
module coordinate_sort_partitioner_core #(
    parameter int MAX_ELEMS  = csp_pkg::MAX_ELEMS_DEF,
    parameter int COORD_BITS = csp_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [csp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [csp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic signed [COORD_BITS-1:0]     x_coord,
    input  logic signed [COORD_BITS-1:0]     y_coord,
    input  logic signed [COORD_BITS-1:0]     z_coord,
    input  logic [csp_pkg::ID_W-1:0]         elem_id,
    input  logic                             last_in,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [csp_pkg::ID_W-1:0]         out_elem_id,
    output logic [csp_pkg::PART_ID_W-1:0]    part_id,
    output logic                             last_out,
    output logic                             overflow
);

    localparam int KEY_W = 2 * COORD_BITS;
    localparam int CNT_W = $clog2(MAX_ELEMS + 1);

    // configuration
    csp_pkg::axis_t              axis_reg;
    csp_pkg::axis_t              axis_next;
    logic [csp_pkg::PARTS_W-1:0] parts_reg;
    logic [csp_pkg::PARTS_W-1:0] parts_next;
    logic [csp_pkg::PARTS_W-1:0] parts_eff;
    logic [csp_pkg::PARTS_W-1:0] parts_m1;

    // key stages
    logic                        item_acc;
    logic [COORD_BITS-1:0]       mag_x;
    logic [COORD_BITS-1:0]       mag_y;
    logic [COORD_BITS-1:0]       mag_z;
    logic [COORD_BITS-1:0]       sel_coord;
    logic [COORD_BITS-1:0]       akey;
    logic                        s1_vld_reg;
    logic                        s1_last_reg;
    logic                        s1_radial_reg;
    logic [csp_pkg::ID_W-1:0]    s1_id_reg;
    logic [COORD_BITS-1:0]       s1_akey_reg;
    logic [KEY_W-1:0]            s1_sqx_reg;
    logic [KEY_W-1:0]            s1_sqy_reg;
    logic [KEY_W-1:0]            s1_sqz_reg;
    logic                        s2_vld_reg;
    logic                        s2_last_reg;
    logic [csp_pkg::ID_W-1:0]    s2_id_reg;
    logic [KEY_W-1:0]            s2_key_reg;

    // control
    csp_pkg::state_t             state_reg;
    csp_pkg::state_t             state_next;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [CNT_W-1:0]            cnt_ins;
    logic                        dropped_reg;
    logic                        dropped_next;
    logic [CNT_W-1:0]            rem_cnt_reg;
    logic [CNT_W-1:0]            rem_cnt_next;
    logic [CNT_W-1:0]            target_reg;
    logic [CNT_W-1:0]            target_next;
    logic [CNT_W-1:0]            in_part_reg;
    logic [CNT_W-1:0]            in_part_next;
    logic [CNT_W-1:0]            in_part_inc;
    logic [csp_pkg::PART_ID_W-1:0] part_reg;
    logic [csp_pkg::PART_ID_W-1:0] part_next;
    logic                        full;
    logic                        div_start;
    logic                        div_done;
    logic [CNT_W-1:0]            div_q;
    csp_pkg::chain_op_t          op;

    // chain
    logic [KEY_W-1:0]            key_w [MAX_ELEMS];
    logic [csp_pkg::ID_W-1:0]    id_w  [MAX_ELEMS];
    logic                        vld_w [MAX_ELEMS];
    logic                        gt_w  [MAX_ELEMS];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        axis_next  = axis_reg;
        parts_next = parts_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                csp_pkg::REG_SORT_AXIS: axis_next  = csp_pkg::axis_t'(cfg_data[1:0]);
                csp_pkg::REG_NUM_PARTS: parts_next = cfg_data;
                default: ;
            endcase
        end
    end

    assign parts_eff = (parts_reg == '0) ? csp_pkg::PARTS_W'(1) : parts_reg;
    assign parts_m1  = parts_eff - csp_pkg::PARTS_W'(1);

    // key forming
    assign item_acc = item_valid && item_ready;
    assign mag_x = x_coord[COORD_BITS-1] ? COORD_BITS'(-x_coord) : COORD_BITS'(x_coord);
    assign mag_y = y_coord[COORD_BITS-1] ? COORD_BITS'(-y_coord) : COORD_BITS'(y_coord);
    assign mag_z = z_coord[COORD_BITS-1] ? COORD_BITS'(-z_coord) : COORD_BITS'(z_coord);

    always_comb
    begin
        case (axis_reg)
            csp_pkg::AXIS_X: sel_coord = x_coord;
            csp_pkg::AXIS_Y: sel_coord = y_coord;
            csp_pkg::AXIS_Z: sel_coord = z_coord;
            default:         sel_coord = x_coord;
        endcase
    end

    assign akey = {~sel_coord[COORD_BITS-1], sel_coord[COORD_BITS-2:0]};

    always_ff @(posedge clk)
    begin
        s1_last_reg   <= last_in;
        s1_radial_reg <= (axis_reg == csp_pkg::AXIS_RADIAL);
        s1_id_reg     <= elem_id;
        s1_akey_reg   <= akey;
        s1_sqx_reg    <= KEY_W'(mag_x) * KEY_W'(mag_x);
        s1_sqy_reg    <= KEY_W'(mag_y) * KEY_W'(mag_y);
        s1_sqz_reg    <= KEY_W'(mag_z) * KEY_W'(mag_z);
        s2_last_reg   <= s1_last_reg;
        s2_id_reg     <= s1_id_reg;
        s2_key_reg    <= s1_radial_reg ? (s1_sqx_reg + s1_sqy_reg + s1_sqz_reg)
                                       : KEY_W'(s1_akey_reg);
    end

    // insertion chain
    assign full   = (count_reg == CNT_W'(MAX_ELEMS));
    assign op.ins = (state_reg == csp_pkg::ST_LOAD) && s2_vld_reg && !full;
    assign op.shf = result_valid && result_ready;

    genvar g;
    for (g = 0; g < MAX_ELEMS; g++)
    begin : g_cell
        logic [KEY_W-1:0]         lk;
        logic [csp_pkg::ID_W-1:0] li;
        logic                     lv;
        logic                     lg;
        logic [KEY_W-1:0]         rk;
        logic [csp_pkg::ID_W-1:0] ri;
        logic                     rv;

        if (g == 0)
        begin : g_head
            assign lk = s2_key_reg;
            assign li = s2_id_reg;
            assign lv = 1'b0;
            assign lg = 1'b0;
        end
        else
        begin : g_body
            assign lk = key_w[g-1];
            assign li = id_w[g-1];
            assign lv = vld_w[g-1];
            assign lg = gt_w[g-1];
        end

        if (g == MAX_ELEMS - 1)
        begin : g_tail
            assign rk = '0;
            assign ri = '0;
            assign rv = 1'b0;
        end
        else
        begin : g_next
            assign rk = key_w[g+1];
            assign ri = id_w[g+1];
            assign rv = vld_w[g+1];
        end

        csp_cell #(
            .KEY_W (KEY_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .op        (op),
            .new_key   (s2_key_reg),
            .new_id    (s2_id_reg),
            .left_key  (lk),
            .left_id   (li),
            .left_vld  (lv),
            .left_gt   (lg),
            .right_key (rk),
            .right_id  (ri),
            .right_vld (rv),
            .key       (key_w[g]),
            .id        (id_w[g]),
            .vld       (vld_w[g]),
            .gt        (gt_w[g])
        );
    end

    // partition size
    assign cnt_ins = op.ins ? CNT_W'(count_reg + 1'b1) : count_reg;

    csp_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cnt_ins),
        .divisor  (parts_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_part_inc = CNT_W'(in_part_reg + 1'b1);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        rem_cnt_next = rem_cnt_reg;
        target_next  = target_reg;
        in_part_next = in_part_reg;
        part_next    = part_reg;
        div_start    = 1'b0;
        case (state_reg)
            csp_pkg::ST_LOAD:
            begin
                if (s2_vld_reg)
                begin
                    count_next = cnt_ins;
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    if (s2_last_reg)
                    begin
                        rem_cnt_next = cnt_ins;
                        div_start    = 1'b1;
                        state_next   = csp_pkg::ST_DIV;
                    end
                end
            end
            csp_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    target_next  = (div_q == '0) ? CNT_W'(1) : div_q;
                    in_part_next = '0;
                    part_next    = '0;
                    if (rem_cnt_reg == '0)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = csp_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = csp_pkg::ST_EMIT;
                    end
                end
            end
            csp_pkg::ST_EMIT:
            begin
                if (result_ready)
                begin
                    rem_cnt_next = CNT_W'(rem_cnt_reg - 1'b1);
                    if (in_part_inc == target_reg)
                    begin
                        in_part_next = '0;
                        if ({1'b0, part_reg} < parts_m1)
                        begin
                            part_next = csp_pkg::PART_ID_W'(part_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        in_part_next = in_part_inc;
                    end
                    if (rem_cnt_reg == CNT_W'(1))
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = csp_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = csp_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg    <= csp_pkg::AXIS_X;
            parts_reg   <= csp_pkg::PARTS_W'(1);
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            state_reg   <= csp_pkg::ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            rem_cnt_reg <= '0;
            target_reg  <= CNT_W'(1);
            in_part_reg <= '0;
            part_reg    <= '0;
        end
        else
        begin
            axis_reg    <= axis_next;
            parts_reg   <= parts_next;
            s1_vld_reg  <= item_acc;
            s2_vld_reg  <= s1_vld_reg;
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            rem_cnt_reg <= rem_cnt_next;
            target_reg  <= target_next;
            in_part_reg <= in_part_next;
            part_reg    <= part_next;
        end
    end

    assign item_ready = (state_reg == csp_pkg::ST_LOAD)
                        && !(s1_vld_reg && s1_last_reg)
                        && !(s2_vld_reg && s2_last_reg);

    assign result_valid = (state_reg == csp_pkg::ST_EMIT);
    assign out_elem_id  = id_w[0];
    assign part_id      = part_reg;
    assign last_out     = (rem_cnt_reg == CNT_W'(1));
    assign overflow     = dropped_reg;

    a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !item_ready)
        else $error("request taken while results pending");

    a_last_closes_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && last_in) |=> !item_ready)
        else $error("batch not closed after last request");

    a_part_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !last_out) |=>
            (result_valid && (part_id >= $past(part_id))))
        else $error("partition id went backwards");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ELEMS))
        else $error("element count above capacity");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csp_pkg::ST_EMIT) |-> (rem_cnt_reg != '0 && vld_w[0]))
        else $error("emitting from an empty chain");

endmodule

>>> rtl/core/csp_cell.sv
// ----------------------------------------------------------------------------
// csp_cell: one slot of the sorted insertion chain
// Holds a key, an id and a valid bit. On insert it keeps its entry, takes the
// new request or takes its left neighbor; on shift it takes its right neighbor.
// ----------------------------------------------------------------------------
module csp_cell #(
    parameter int KEY_W = 2 * csp_pkg::COORD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  csp_pkg::chain_op_t       op,
    input  logic [KEY_W-1:0]         new_key,
    input  logic [csp_pkg::ID_W-1:0] new_id,
    input  logic [KEY_W-1:0]         left_key,
    input  logic [csp_pkg::ID_W-1:0] left_id,
    input  logic                     left_vld,
    input  logic                     left_gt,
    input  logic [KEY_W-1:0]         right_key,
    input  logic [csp_pkg::ID_W-1:0] right_id,
    input  logic                     right_vld,
    output logic [KEY_W-1:0]         key,
    output logic [csp_pkg::ID_W-1:0] id,
    output logic                     vld,
    output logic                     gt
);

    logic [KEY_W-1:0]         key_reg;
    logic [KEY_W-1:0]         key_next;
    logic [csp_pkg::ID_W-1:0] id_reg;
    logic [csp_pkg::ID_W-1:0] id_next;
    logic                     vld_reg;
    logic                     vld_next;

    // empty slots order after everything; equal keys keep arrival order
    assign gt = !vld_reg || (key_reg > new_key);

    always_comb
    begin
        key_next = key_reg;
        id_next  = id_reg;
        vld_next = vld_reg;
        if (op.shf)
        begin
            key_next = right_key;
            id_next  = right_id;
            vld_next = right_vld;
        end
        else if (op.ins && gt)
        begin
            if (left_gt)
            begin
                key_next = left_key;
                id_next  = left_id;
                vld_next = left_vld;
            end
            else
            begin
                key_next = new_key;
                id_next  = new_id;
                vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        id_reg  <= id_next;
    end

    assign key = key_reg;
    assign id  = id_reg;
    assign vld = vld_reg;

endmodule

>>> rtl/core/csp_div.sv
// ----------------------------------------------------------------------------
// csp_div: radix-2 restoring divider for the partition size
// Divides the element count by the partition count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module csp_div #(
    parameter int CNT_W = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [CNT_W-1:0]            dividend,
    input  logic [csp_pkg::PARTS_W-1:0] divisor,
    output logic                        done,
    output logic [CNT_W-1:0]            quotient
);

    localparam int STEP_W = $clog2(CNT_W + 1);

    logic                        busy_reg;
    logic                        busy_next;
    logic                        done_reg;
    logic                        done_next;
    logic [STEP_W-1:0]           step_reg;
    logic [STEP_W-1:0]           step_next;
    logic [csp_pkg::PARTS_W-1:0] rem_reg;
    logic [csp_pkg::PARTS_W-1:0] rem_next;
    logic [csp_pkg::PARTS_W-1:0] dvs_reg;
    logic [csp_pkg::PARTS_W-1:0] dvs_next;
    logic [CNT_W-1:0]            dq_reg;
    logic [CNT_W-1:0]            dq_next;
    logic [csp_pkg::PARTS_W:0]   trial;
    logic [csp_pkg::PARTS_W:0]   diff;

    assign trial = {rem_reg, dq_reg[CNT_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dq_next   = dq_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            dq_next   = dividend;
        end
        else if (busy_reg)
        begin
            if (!diff[csp_pkg::PARTS_W])
            begin
                rem_next = diff[csp_pkg::PARTS_W-1:0];
                dq_next  = {dq_reg[CNT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[csp_pkg::PARTS_W-1:0];
                dq_next  = {dq_reg[CNT_W-2:0], 1'b0};
            end
            step_next = STEP_W'(step_reg + 1'b1);
            if (step_reg == STEP_W'(CNT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dq_reg  <= dq_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

>>> sim/csp_order_checker.sv
// ----------------------------------------------------------------------------
// csp_order_checker: predicts and checks the sorted, partitioned result stream
// Watches the config, element and result channels of the partitioner. Keeps
// its own sorted copy of the batch (key and id, stable on ties) and, on the
// request marked last, queues the expected id, part, last and overflow of
// every stored element. Each accepted result is compared with the oldest one.
// ----------------------------------------------------------------------------
module csp_order_checker #(
    parameter int MAX_ELEMS  = 64,
    parameter int COORD_BITS = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [csp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [csp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             item_valid,
    input  logic                             item_ready,
    input  logic signed [COORD_BITS-1:0]     x_coord,
    input  logic signed [COORD_BITS-1:0]     y_coord,
    input  logic signed [COORD_BITS-1:0]     z_coord,
    input  logic [csp_pkg::ID_W-1:0]         elem_id,
    input  logic                             last_in,
    input  logic                             result_valid,
    input  logic                             result_ready,
    input  logic [csp_pkg::ID_W-1:0]         out_elem_id,
    input  logic [csp_pkg::PART_ID_W-1:0]    part_id,
    input  logic                             last_out,
    input  logic                             overflow,
    output int                               outstanding,
    output int                               mismatches,
    output int                               batches_seen,
    output int                               results_seen
);

    typedef struct packed {
        logic [csp_pkg::ID_W-1:0]      id;
        logic [csp_pkg::PART_ID_W-1:0] part;
        logic                          last;
        logic                          ovf;
    } placed_t;

    logic [48:0]                  key_arr [MAX_ELEMS];
    logic [csp_pkg::ID_W-1:0]     id_arr  [MAX_ELEMS];
    int                           stored;
    logic                         dropped;
    csp_pkg::axis_t               axis_sel;
    logic [csp_pkg::PARTS_W-1:0]  parts_sel;
    placed_t                      sorted_q [$];

    function automatic logic [48:0] axis_key(input logic signed [COORD_BITS-1:0] v);
        logic [COORD_BITS-1:0] t;
        t = v;
        t[COORD_BITS-1] = ~t[COORD_BITS-1];
        return 49'(t);
    endfunction

    function automatic logic [48:0] square_mag(input logic signed [COORD_BITS-1:0] v);
        logic [COORD_BITS-1:0] m;
        m = v[COORD_BITS-1] ? (~v + 1'b1) : v;
        return 49'(m) * 49'(m);
    endfunction

    function automatic logic [48:0] key_of(input logic signed [COORD_BITS-1:0] xv,
                                           input logic signed [COORD_BITS-1:0] yv,
                                           input logic signed [COORD_BITS-1:0] zv);
        case (axis_sel)
            csp_pkg::AXIS_X: return axis_key(xv);
            csp_pkg::AXIS_Y: return axis_key(yv);
            csp_pkg::AXIS_Z: return axis_key(zv);
            default:         return square_mag(xv) + square_mag(yv) + square_mag(zv);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [48:0] k;
        int          pos;
        int          parts;
        int          target;
        int          p;
        placed_t     exp_r;
        if (!rst_n)
        begin
            stored    = 0;
            dropped   = 1'b0;
            axis_sel  = csp_pkg::AXIS_X;
            parts_sel = csp_pkg::PARTS_W'(1);
            sorted_q.delete();
            outstanding  <= 0;
            mismatches   = 0;
            batches_seen = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    csp_pkg::REG_SORT_AXIS: axis_sel = csp_pkg::axis_t'(cfg_data[1:0]);
                    csp_pkg::REG_NUM_PARTS: parts_sel = cfg_data;
                    default: ;
                endcase
            end

            if (result_valid && result_ready)
            begin
                results_seen++;
                if (sorted_q.size() == 0)
                begin
                    $error("unexpected result: out_elem_id %0d part_id %0d", out_elem_id, part_id);
                    mismatches++;
                end
                else
                begin
                    exp_r = sorted_q.pop_front();
                    if (out_elem_id !== exp_r.id)
                    begin
                        $error("out_elem_id: expected %0d, actual %0d", exp_r.id, out_elem_id);
                        mismatches++;
                    end
                    if (part_id !== exp_r.part)
                    begin
                        $error("part_id: expected %0d, actual %0d", exp_r.part, part_id);
                        mismatches++;
                    end
                    if (last_out !== exp_r.last)
                    begin
                        $error("last_out: expected %0d, actual %0d", exp_r.last, last_out);
                        mismatches++;
                    end
                    if (overflow !== exp_r.ovf)
                    begin
                        $error("overflow: expected %0d, actual %0d", exp_r.ovf, overflow);
                        mismatches++;
                    end
                end
            end

            if (item_valid && item_ready)
            begin
                if (stored < MAX_ELEMS)
                begin
                    k = key_of(x_coord, y_coord, z_coord);
                    pos = stored;
                    while (pos > 0 && key_arr[pos-1] > k)
                    begin
                        key_arr[pos] = key_arr[pos-1];
                        id_arr[pos]  = id_arr[pos-1];
                        pos--;
                    end
                    key_arr[pos] = k;
                    id_arr[pos]  = elem_id;
                    stored++;
                end
                else
                    dropped = 1'b1;

                if (last_in)
                begin
                    batches_seen++;
                    parts  = (parts_sel == 0) ? 1 : int'(parts_sel);
                    target = stored / parts;
                    if (target == 0)
                        target = 1;
                    for (int i = 0; i < stored; i++)
                    begin
                        p = i / target;
                        if (p > parts - 1)
                            p = parts - 1;
                        exp_r.id   = id_arr[i];
                        exp_r.part = csp_pkg::PART_ID_W'(p);
                        exp_r.last = (i == stored - 1);
                        exp_r.ovf  = dropped;
                        sorted_q.insert(sorted_q.size(), exp_r);
                    end
                    stored  = 0;
                    dropped = 1'b0;
                end
            end

            outstanding <= sorted_q.size();
        end
    end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for coordinate_sort_partitioner_core
// Directed batches hit coordinate and id extremes, ties, every sort key, zero
// and oversized part counts, ignored register indexes and a key change in the
// middle of a batch; random batches follow under three idling mixes, with a
// batch that fills and then overflows capacity. csp_order_checker predicts
// and checks; this module drives requests and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_ELEMS  = 64;
    localparam int COORD_BITS = 24;
    localparam int SETTLE     = 16;
    localparam int WATCHDOG   = 2000;
    localparam int PHASE_ITEMS = 6;

    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [csp_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [csp_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
    logic                              item_valid = 1'b0;
    logic                              item_ready;
    logic signed [COORD_BITS-1:0]      x_coord = '0;
    logic signed [COORD_BITS-1:0]      y_coord = '0;
    logic signed [COORD_BITS-1:0]      z_coord = '0;
    logic [csp_pkg::ID_W-1:0]          elem_id = '0;
    logic                              last_in = 1'b0;
    logic                              result_valid;
    logic                              result_ready = 1'b0;
    logic [csp_pkg::ID_W-1:0]          out_elem_id;
    logic [csp_pkg::PART_ID_W-1:0]     part_id;
    logic                              last_out;
    logic                              overflow;

    int outstanding;
    int mismatches;
    int batches_seen;
    int results_seen;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int quiet_cycles = 0;

    coordinate_sort_partitioner_core #(
        .MAX_ELEMS (MAX_ELEMS),
        .COORD_BITS(COORD_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .z_coord     (z_coord),
        .elem_id     (elem_id),
        .last_in     (last_in),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .out_elem_id (out_elem_id),
        .part_id     (part_id),
        .last_out    (last_out),
        .overflow    (overflow)
    );

    csp_order_checker #(
        .MAX_ELEMS (MAX_ELEMS),
        .COORD_BITS(COORD_BITS)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .z_coord     (z_coord),
        .elem_id     (elem_id),
        .last_in     (last_in),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .out_elem_id (out_elem_id),
        .part_id     (part_id),
        .last_out    (last_out),
        .overflow    (overflow),
        .outstanding (outstanding),
        .mismatches  (mismatches),
        .batches_seen(batches_seen),
        .results_seen(results_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        result_ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [csp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [csp_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic push_elem(input logic signed [COORD_BITS-1:0] xv,
                             input logic signed [COORD_BITS-1:0] yv,
                             input logic signed [COORD_BITS-1:0] zv,
                             input logic [csp_pkg::ID_W-1:0] id,
                             input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        x_coord    <= xv;
        y_coord    <= yv;
        z_coord    <= zv;
        elem_id    <= id;
        last_in    <= last;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // hold off requests until every queued result is out, then let the
    // key stages and divider settle
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        int v;
        v = $urandom_range(0, 32);
        case ($urandom_range(0, 7))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return '0;
            3:       return COORD_BITS'(v - 16);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [csp_pkg::CFG_DATA_W-1:0] rand_parts();
        case ($urandom_range(0, 5))
            0:       return csp_pkg::CFG_DATA_W'(0);
            1:       return csp_pkg::CFG_DATA_W'(1);
            2:       return csp_pkg::CFG_DATA_W'(64);
            3:       return csp_pkg::CFG_DATA_W'(127);
            default: return csp_pkg::CFG_DATA_W'($urandom_range(1, 64));
        endcase
    endfunction

    task automatic rand_batch(input int n);
        for (int i = 0; i < n; i++)
            push_elem(rand_coord(), rand_coord(), rand_coord(), csp_pkg::ID_W'($urandom),
                      i == n - 1);
        drain_results();
    endtask

    initial
    begin : stimulus
        int sent;
        int n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: x key, one part; extremes and ties on x
        push_elem(C_MIN, 0, 0, 16'h0000, 1'b0);
        push_elem(C_MAX, C_MIN, C_MAX, 16'hFFFF, 1'b0);
        push_elem(0, C_MAX, C_MIN, 16'h0003, 1'b0);
        push_elem(-1, 5, 5, 16'h0004, 1'b0);
        push_elem(1, -5, -5, 16'h0005, 1'b0);
        push_elem(C_MIN, 7, 7, 16'h0006, 1'b1);
        drain_results();

        // y key with fewer elements than parts
        write_reg(csp_pkg::REG_SORT_AXIS, csp_pkg::CFG_DATA_W'(csp_pkg::AXIS_Y));
        write_reg(csp_pkg::REG_NUM_PARTS, csp_pkg::CFG_DATA_W'(64));
        push_elem(0, C_MAX, 0, 16'h0101, 1'b0);
        push_elem(0, C_MIN, 0, 16'h0102, 1'b0);
        push_elem(0, 0, 0, 16'h0103, 1'b1);
        drain_results();

        // z key, zero parts, writes to unused indexes are ignored
        write_reg(csp_pkg::REG_SORT_AXIS, csp_pkg::CFG_DATA_W'(csp_pkg::AXIS_Z));
        write_reg(csp_pkg::REG_NUM_PARTS, csp_pkg::CFG_DATA_W'(0));
        write_reg(2'd2, 7'h7F);
        write_reg(2'd3, 7'h7F);
        push_elem(0, 0, C_MAX, 16'h0201, 1'b0);
        push_elem(0, 0, -1, 16'h0202, 1'b0);
        push_elem(0, 0, -1, 16'h0203, 1'b0);
        push_elem(0, 0, C_MIN, 16'h0204, 1'b1);
        drain_results();

        // radial key, largest magnitudes and ties
        write_reg(csp_pkg::REG_SORT_AXIS, 7'h7C | csp_pkg::CFG_DATA_W'(csp_pkg::AXIS_RADIAL));
        write_reg(csp_pkg::REG_NUM_PARTS, csp_pkg::CFG_DATA_W'(2));
        push_elem(C_MIN, C_MIN, C_MIN, 16'h0301, 1'b0);
        push_elem(C_MAX, C_MAX, C_MAX, 16'h0302, 1'b0);
        push_elem(0, 0, 0, 16'h0303, 1'b0);
        push_elem(1, -1, 0, 16'h0304, 1'b0);
        push_elem(-1, 1, 0, 16'h0305, 1'b1);
        drain_results();

        // key changes in the middle of a batch
        write_reg(csp_pkg::REG_SORT_AXIS, csp_pkg::CFG_DATA_W'(csp_pkg::AXIS_X));
        write_reg(csp_pkg::REG_NUM_PARTS, csp_pkg::CFG_DATA_W'(3));
        push_elem(100, -100, 0, 16'h0401, 1'b0);
        push_elem(-100, 100, 0, 16'h0402, 1'b0);
        drain_results();
        write_reg(csp_pkg::REG_SORT_AXIS, csp_pkg::CFG_DATA_W'(csp_pkg::AXIS_Y));
        push_elem(C_MAX, C_MIN, 0, 16'h0403, 1'b0);
        push_elem(C_MIN, C_MAX, 0, 16'h0404, 1'b1);
        drain_results();

        // single element batch
        push_elem(C_MAX, C_MAX, C_MAX, 16'h5AA5, 1'b1);
        drain_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 85 : 0;
            rx_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 22 : 0;
            if (phase == 0)
            begin
                // full chain, then the dropped request carries last
                write_reg(csp_pkg::REG_SORT_AXIS, csp_pkg::CFG_DATA_W'($urandom));
                write_reg(csp_pkg::REG_NUM_PARTS, csp_pkg::CFG_DATA_W'(5));
                rand_batch(MAX_ELEMS + 1);
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                write_reg(csp_pkg::REG_SORT_AXIS, csp_pkg::CFG_DATA_W'($urandom));
                write_reg(csp_pkg::REG_NUM_PARTS, rand_parts());
                n = $urandom_range(1, 6);
                rand_batch(n);
                sent += n;
            end
        end

        $display("covered %0d batches, %0d results: all sort keys, part counts 0 to 127,",
                 batches_seen, results_seen);
        $display("ties, a full batch, a dropped-request batch and three idling mixes");
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/csp_pkg.sv
rtl/core/csp_cell.sv
rtl/core/csp_div.sv
rtl/core/coordinate_sort_partitioner_core.sv
sim/csp_order_checker.sv
sim/tb_top.sv
